// File: design/brq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brq_pkg
// shared widths, codes and control structs of the bounded result queue
// ----------------------------------------------------------------------------
package brq_pkg;

   localparam int ADDR_W     = 48;
   localparam int CODE_W     = 32;
   localparam int ENTRY_W    = ADDR_W + CODE_W;
   localparam int ACT_W      = 3;
   localparam int CNT_W      = 4;
   localparam int STAT_W     = 2;
   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 88;

   localparam int DEPTH_DEFAULT = 8;

   localparam logic [CNT_W-1:0] LIMIT_RESET = 4'd8;

   // request actions
   localparam logic [ACT_W-1:0] ACT_NEW     = 3'd0;
   localparam logic [ACT_W-1:0] ACT_REQUEST = 3'd1;
   localparam logic [ACT_W-1:0] ACT_CANCEL  = 3'd2;
   localparam logic [ACT_W-1:0] ACT_REG     = 3'd3;
   localparam logic [ACT_W-1:0] ACT_RELEASE = 3'd4;

   // response status codes
   localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STAT_W-1:0] STAT_ALREADY  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_IGNORED  = 2'd2;

   typedef struct packed {
      logic exec;
      logic load;
   } ctl_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

// File: design/brq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brq_ctrl
// two-state sequencer: take a request, then load its response
// ----------------------------------------------------------------------------
module brq_ctrl
   import brq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type sts,
   output ctl_cmd_type   cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_LOAD = 1'b1;

   logic state_ff;
   logic state_in;

   always_comb begin
      state_in = state_ff;
      cmd.exec = 1'b0;
      cmd.load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.exec = 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (sts.out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: design/brq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brq_datapath
// ring store, head and count, flags, limit register and response register
// ----------------------------------------------------------------------------
module brq_datapath
   import brq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [ACT_W-1:0]      req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CNT_W-1:0]      csr_wdata,
   input  ctl_cmd_type           cmd,
   output dp_status_type         sts
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SUM_W = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 1;
   localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);

   // one conditional subtract is enough: every sum stays below twice the depth
   function automatic logic [PTR_W-1:0] wrap(input logic [SUM_W-1:0] v);
      logic [SUM_W-1:0] r;
      r = (v >= DEPTH_S) ? (v - DEPTH_S) : v;
      return r[PTR_W-1:0];
   endfunction

   logic [ENTRY_W-1:0]    mem_ff [DEPTH];
   logic [ENTRY_W-1:0]    rd_data_ff;
   logic [PTR_W-1:0]      head_ff, head_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  pend_ff, pend_in;
   logic                  cons_ff, cons_in;
   logic [CNT_W-1:0]      limit_ff;
   logic [ADDR_W-1:0]     in_addr_ff;
   logic [CODE_W-1:0]     in_code_ff;
   logic                  res_deliver_ff, res_bypass_ff, res_drop_ff;
   logic [STAT_W-1:0]     res_status_ff;
   logic [CNT_W-1:0]      res_count_ff;
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic [ACT_W-1:0]  act;
   logic [ADDR_W-1:0] addr;
   logic [CODE_W-1:0] code;
   logic              accepts;
   logic [CNT_W-1:0]  lim_eff;
   logic [PTR_W-1:0]  head_mid, slot, rd_addr;
   logic [CNT_W-1:0]  cnt_mid;
   logic              wr_en, deliver, bypass, dropped;
   logic [STAT_W-1:0] status;
   logic [ENTRY_W-1:0] out_entry;

   assign act     = req_tuser;
   assign addr    = req_tdata[ADDR_W-1:0];
   assign code    = req_tdata[ADDR_W +: CODE_W];
   assign accepts = req_tdata[ENTRY_W];

   always_comb begin
      if (limit_ff == '0) begin
         lim_eff = CNT_W'(1);
      end else if (SUM_W'(limit_ff) > DEPTH_S) begin
         lim_eff = CNT_W'(DEPTH);
      end else begin
         lim_eff = limit_ff;
      end
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      pend_in  = pend_ff;
      cons_in  = cons_ff;
      head_mid = head_ff;
      cnt_mid  = count_ff;
      slot     = head_ff;
      rd_addr  = head_ff;
      wr_en    = 1'b0;
      deliver  = 1'b0;
      bypass   = 1'b0;
      dropped  = 1'b0;
      status   = STAT_OK;
      case (act)
         ACT_NEW: begin
            if (!cons_ff) begin
               status = STAT_IGNORED;
            end else begin
               // trim down to one below the limit, then push
               if (count_ff >= lim_eff) begin
                  head_mid = wrap(SUM_W'(head_ff)
                                  + SUM_W'(CNT_W'(count_ff + CNT_W'(1) - lim_eff)));
                  cnt_mid  = lim_eff - CNT_W'(1);
                  dropped  = 1'b1;
               end
               slot     = wrap(SUM_W'(head_mid) + SUM_W'(cnt_mid));
               wr_en    = 1'b1;
               head_in  = head_mid;
               count_in = cnt_mid + CNT_W'(1);
               if (pend_ff) begin
                  pend_in = 1'b0;
                  deliver = 1'b1;
                  bypass  = (cnt_mid == '0);
                  rd_addr = head_mid;
                  if (accepts) begin
                     head_in  = wrap(SUM_W'(head_mid) + SUM_W'(1));
                     count_in = cnt_mid;
                  end
               end
            end
         end
         ACT_REQUEST: begin
            if (count_ff != '0) begin
               deliver = 1'b1;
               if (accepts) begin
                  head_in  = wrap(SUM_W'(head_ff) + SUM_W'(1));
                  count_in = count_ff - CNT_W'(1);
               end
            end else begin
               pend_in = 1'b1;
            end
         end
         ACT_CANCEL: begin
            pend_in = 1'b0;
         end
         ACT_REG: begin
            if (cons_ff) begin
               status = STAT_ALREADY;
            end else begin
               cons_in = 1'b1;
            end
         end
         ACT_RELEASE: begin
            if (!cons_ff) begin
               status = STAT_IGNORED;
            end else begin
               cons_in  = 1'b0;
               count_in = '0;
               head_in  = '0;
            end
         end
         default: ;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         cons_ff      <= 1'b0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.exec) begin
            head_ff  <= head_in;
            count_ff <= count_in;
            pend_ff  <= pend_in;
            cons_ff  <= cons_in;
         end
         if (csr_valid) begin
            limit_ff <= csr_wdata;
         end
         if (cmd.load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ring store, registered read of the head
   always_ff @(posedge clock) begin
      if (cmd.exec && wr_en) begin
         mem_ff[slot] <= {code, addr};
      end
      if (cmd.exec) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   // request payload and response fields held until the load
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         in_addr_ff     <= addr;
         in_code_ff     <= code;
         res_deliver_ff <= deliver;
         res_bypass_ff  <= bypass;
         res_drop_ff    <= dropped;
         res_status_ff  <= status;
         res_count_ff   <= count_in;
      end
   end

   // freshly written entry at the head is taken from the request itself
   always_comb begin
      if (!res_deliver_ff) begin
         out_entry = '0;
      end else if (res_bypass_ff) begin
         out_entry = {in_code_ff, in_addr_ff};
      end else begin
         out_entry = rd_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_data_ff <= {res_count_ff, res_drop_ff, res_status_ff, out_entry,
                         res_deliver_ff};
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign csr_ready    = 1'b1;
   assign sts.out_free = !rsp_valid_ff || rsp_tready;

`ifndef SYNTHESIS
   a_count_fits: assert property (@(posedge clock) disable iff (reset)
      SUM_W'(count_ff) <= DEPTH_S)
      else $error("entry count above depth");

   a_entries_need_consumer: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> cons_ff)
      else $error("entries held without a consumer");

   a_pending_only_empty: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (count_ff == '0))
      else $error("pending request while entries are held");

   a_load_into_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (!rsp_valid_ff || rsp_tready))
      else $error("response loaded over an unaccepted one");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> !cmd.exec)
      else $error("request taken while previous one in flight");
`endif

endmodule

// File: design/bounded_result_queue_drop_oldest.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_result_queue_drop_oldest
// single-consumer result queue with drop-oldest trimming and pending request
// ----------------------------------------------------------------------------
// an accepted request is registered, then its response is loaded into the output
//   register once that register is empty or drains in that cycle
// a new request is taken only after the previous response is loaded, as set by
//   the two-state sequencer; the registered ring read is ready for that load
// reset: synchronous, clears head, count, pending and consumer flags, sets
//   the limit to 8; the ring store is not cleared, as only written entries are read
module bounded_result_queue_drop_oldest
   import brq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
)
(
   input  logic                  clock,
   input  logic                  reset,
   // request: tdata = device_address[47:0], result_code[79:48],
   //   consumer_accepts[80], zero pad[87:81]
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // request: tuser = action[2:0]
   input  logic [ACT_W-1:0]      req_tuser,
   // response: tdata = delivered[0], delivered_address[48:1],
   //   delivered_result[80:49], status[82:81], dropped_oldest[83],
   //   entries_held[87:84]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // limit register write (max_entries)
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CNT_W-1:0]      csr_wdata
);

   ctl_cmd_type   cmd;
   dp_status_type sts;

   // sequencer: idle takes a request, load moves its response out
   brq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // ring store, pointers, flags and the response register
   brq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule
